// ===== design/apf_pkg.sv =====
// ----------------------------------------------------------------------------
// apf_pkg: shared types and constants of the articulation point finder
// Node and counter widths, datapath operation codes, the command and
// status bundles between controller and datapath, and the walk frame.
// ----------------------------------------------------------------------------
package apf_pkg;

    localparam int NODE_W = 6;   // node number width
    localparam int PTR_W  = 7;   // neighbor pointer, holds 0 .. 64
    localparam int VIS_W  = 7;   // visit numbers and low links
    localparam int CNT_W  = 6;   // child and subnet counts
    localparam int NET_W  = 16;  // network counter
    localparam int CHUNK  = 8;   // adjacency bits examined per scan cycle
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 32;

    typedef logic [NODE_W-1:0] node_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_EDGE,
        OP_RSCAN_INIT,
        OP_RSCAN,
        OP_ROOT_START,
        OP_FETCH,
        OP_SCAN,
        OP_VCMP,
        OP_PUSH,
        OP_POP,
        OP_UNWIND,
        OP_REP_START,
        OP_REP_SCAN,
        OP_EMIT,
        OP_EMIT_NONE,
        OP_CLEAR
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic rscan_end;    // root search ran past the last node
        logic root_hit;     // current node starts a new walk
        logic scan_found;   // a neighbor was found this cycle
        logic scan_end;     // the neighbor row is exhausted
        logic w_visited;    // the found neighbor already has a visit number
        logic back_ok;      // the found neighbor is not the tree parent
        logic stack_empty;  // the current frame is a walk root
        logic rep_end;      // report scan ran past the last node
        logic rep_cut;      // report scan stands on a cut vertex
        logic out_busy;     // output register holds an untaken beat
        logic no_cuts;      // the walk found no cut vertex
    } dp_status_t;

    typedef struct packed {
        node_t             u;
        node_t             par;    // zero marks a walk root
        logic [PTR_W-1:0]  nxt;
        logic [CNT_W-1:0]  child;
        logic [VIS_W-1:0]  vis;
        logic [VIS_W-1:0]  low;
        logic [VIS_W-1:0]  split;
    } frame_t;

endpackage

// ===== design/apf_ctrl.sv =====
// ----------------------------------------------------------------------------
// apf_ctrl: sequencer of the articulation point finder
// Accepts edge and end beats, then steps the datapath through the root
// search, the depth-first walk, the report and the final clear.
// ----------------------------------------------------------------------------
module apf_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic                s_kind,
    input  apf_pkg::dp_status_t status,
    output apf_pkg::dp_cmd_t    cmd
);
    import apf_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RSCAN,
        ST_ROOT,
        ST_FETCH,
        ST_SCAN,
        ST_VCMP,
        ST_PUSH,
        ST_POP,
        ST_UNWIND,
        ST_REP_START,
        ST_REP_SCAN,
        ST_EMIT,
        ST_NONE,
        ST_CLEAR
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg;
    dp_op_t op;

    assign s_tready = ready_reg;
    assign cmd.op   = op;

    always_comb begin
        state_next = state_reg;
        op         = OP_NOP;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && ready_reg) begin
                    if (s_kind) begin
                        op         = OP_RSCAN_INIT;
                        state_next = ST_RSCAN;
                    end else begin
                        op = OP_EDGE;
                    end
                end
            end
            ST_RSCAN: begin
                op = OP_RSCAN;
                if (status.rscan_end) begin
                    state_next = ST_REP_START;
                end else if (status.root_hit) begin
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT: begin
                op         = OP_ROOT_START;
                state_next = ST_FETCH;
            end
            ST_FETCH: begin
                op         = OP_FETCH;
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                op = OP_SCAN;
                if (status.scan_found) begin
                    if (!status.w_visited) begin
                        state_next = ST_PUSH;
                    end else if (status.back_ok) begin
                        state_next = ST_VCMP;
                    end
                end else if (status.scan_end) begin
                    state_next = ST_POP;
                end
            end
            ST_VCMP: begin
                op         = OP_VCMP;
                state_next = ST_SCAN;
            end
            ST_PUSH: begin
                op         = OP_PUSH;
                state_next = ST_FETCH;
            end
            ST_POP: begin
                op         = OP_POP;
                state_next = status.stack_empty ? ST_RSCAN : ST_UNWIND;
            end
            ST_UNWIND: begin
                op         = OP_UNWIND;
                state_next = ST_FETCH;
            end
            ST_REP_START: begin
                if (!status.out_busy) begin
                    op         = OP_REP_START;
                    state_next = ST_REP_SCAN;
                end
            end
            ST_REP_SCAN: begin
                // Hold while the previous beat still waits to be taken.
                if (!status.out_busy) begin
                    op = OP_REP_SCAN;
                    if (status.rep_end) begin
                        state_next = status.no_cuts ? ST_NONE : ST_CLEAR;
                    end else if (status.rep_cut) begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                op         = OP_EMIT;
                state_next = ST_REP_SCAN;
            end
            ST_NONE: begin
                op         = OP_EMIT_NONE;
                state_next = ST_CLEAR;
            end
            ST_CLEAR: begin
                op         = OP_CLEAR;
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b1;
        end else begin
            state_reg <= state_next;
            ready_reg <= (state_next == ST_IDLE);
        end
    end

endmodule

// ===== design/apf_datapath.sv =====
// ----------------------------------------------------------------------------
// apf_datapath: storage and arithmetic of the articulation point finder
// Holds the adjacency memories, visit numbers, walk stack, cut results
// and the output register, and carries out one command per cycle.
// ----------------------------------------------------------------------------
module apf_datapath #(
    parameter int MAX_NODES = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  apf_pkg::dp_cmd_t              cmd,
    output apf_pkg::dp_status_t           status,
    input  apf_pkg::node_t                edge_a,
    input  apf_pkg::node_t                edge_b,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [apf_pkg::M_DATA_W-1:0]  m_tdata,
    output logic                          m_tlast,
    output logic                          m_none
);
    import apf_pkg::*;

    localparam int NODES   = (MAX_NODES < 64) ? MAX_NODES : 64;
    localparam int IDX_W   = $clog2(NODES);
    localparam int CHUNKS  = (NODES + CHUNK - 1) / CHUNK;
    localparam int ROW_PAD = CHUNKS * CHUNK;
    localparam logic [PTR_W-1:0] NODE_LIM = PTR_W'(NODES);
    localparam int PAD_W   = M_DATA_W - NET_W - 2 * NODE_W;

    // Adjacency is split in two memories so that both halves of an edge
    // are written in the same cycle: row a gets bit b, row b gets bit a.
    logic [NODES-1:0] fwd_mem [NODES];
    logic [NODES-1:0] rev_mem [NODES];
    logic [VIS_W-1:0] vis_mem [NODES];
    logic [CNT_W-1:0] sub_mem [NODES];
    frame_t           stack_mem [NODES];

    logic [NODES-1:0] fwd_valid_reg, rev_valid_reg, visited_reg, cut_reg;
    logic [NODES-1:0] fwd_rd_reg, rev_rd_reg;
    logic             fwd_rdv_reg, rev_rdv_reg;
    logic [VIS_W-1:0] vis_rd_reg;
    logic [CNT_W-1:0] sub_rd_reg;
    frame_t           stack_rd_reg;

    frame_t           frame_reg;
    logic [IDX_W-1:0] sp_reg;
    logic [PTR_W-1:0] i_reg;
    node_t            w_reg;
    logic [VIS_W-1:0] vcnt_reg;
    logic [NET_W-1:0] net_reg;
    logic [CNT_W-1:0] cut_total_reg, rep_cnt_reg;

    logic                out_valid_reg, out_last_reg, out_none_reg;
    logic [M_DATA_W-1:0] out_data_reg;

    // Edge qualification.
    logic             edge_ok;
    logic [IDX_W-1:0] a_idx, b_idx;

    assign a_idx   = edge_a[IDX_W-1:0];
    assign b_idx   = edge_b[IDX_W-1:0];
    assign edge_ok = (edge_a != '0) && (edge_b != '0) &&
                     ({1'b0, edge_a} < NODE_LIM) && ({1'b0, edge_b} < NODE_LIM);

    // Neighbor scan over one chunk of the current row per cycle.
    logic [NODES-1:0]   row;
    logic [ROW_PAD-1:0] row_pad;
    logic [CHUNK-1:0]   chunk_bits;
    logic [PTR_W-4:0]   cidx;
    logic [2:0]         wk;
    logic               found;
    logic [PTR_W-1:0]   w_ptr, next_base;
    node_t              w_node;
    logic               scan_done;

    assign row     = (fwd_rdv_reg ? fwd_rd_reg : '0) | (rev_rdv_reg ? rev_rd_reg : '0);
    assign row_pad = ROW_PAD'(row);
    assign cidx    = frame_reg.nxt[PTR_W-1:3];

    always_comb begin
        chunk_bits = '0;
        for (int c = 0; c < CHUNKS; c++) begin
            if (c == int'(cidx)) begin
                chunk_bits = row_pad[c*CHUNK +: CHUNK];
            end
        end
        found = 1'b0;
        wk    = '0;
        for (int k = 0; k < CHUNK; k++) begin
            if (!found && chunk_bits[k] && (3'(k) >= frame_reg.nxt[2:0])) begin
                found = 1'b1;
                wk    = 3'(k);
            end
        end
        if (frame_reg.nxt >= NODE_LIM) begin
            found = 1'b0;
        end
    end

    assign w_ptr     = {cidx, wk};
    assign w_node    = w_ptr[NODE_W-1:0];
    assign next_base = {cidx + 1'b1, 3'b000};
    assign scan_done = (frame_reg.nxt >= NODE_LIM) || (!found && (next_base >= NODE_LIM));

    // Frame arithmetic for push, pop and unwind.
    frame_t           push_frame, new_frame, up_frame;
    logic             cut_now;
    logic [VIS_W-1:0] fin_count;
    logic [IDX_W-1:0] w_idx, u_idx, i_idx;

    assign w_idx = w_reg[IDX_W-1:0];
    assign u_idx = frame_reg.u[IDX_W-1:0];
    assign i_idx = i_reg[IDX_W-1:0];

    always_comb begin
        push_frame       = frame_reg;
        push_frame.child = frame_reg.child + 1'b1;

        new_frame.u     = w_reg;
        new_frame.par   = frame_reg.u;
        new_frame.nxt   = '0;
        new_frame.child = '0;
        new_frame.vis   = vcnt_reg + 1'b1;
        new_frame.low   = vcnt_reg + 1'b1;
        new_frame.split = '0;

        // A root splits only with two or more children; any other node
        // splits when one child cannot reach above it.
        if (frame_reg.par == '0) begin
            cut_now   = (frame_reg.child >= CNT_W'(2));
            fin_count = frame_reg.split;
        end else begin
            cut_now   = (frame_reg.split != '0);
            fin_count = frame_reg.split + 1'b1;
        end

        up_frame = stack_rd_reg;
        if (frame_reg.low < stack_rd_reg.low) begin
            up_frame.low = frame_reg.low;
        end
        if (frame_reg.low >= stack_rd_reg.vis) begin
            up_frame.split = stack_rd_reg.split + 1'b1;
        end
    end

    always_comb begin
        status.rscan_end   = (i_reg >= NODE_LIM);
        status.root_hit    = (i_reg < NODE_LIM) && !visited_reg[i_idx] &&
                             (fwd_valid_reg[i_idx] || rev_valid_reg[i_idx]);
        status.scan_found  = found;
        status.scan_end    = scan_done;
        status.w_visited   = visited_reg[w_node[IDX_W-1:0]];
        status.back_ok     = (frame_reg.par == '0) || (w_node != frame_reg.par);
        status.stack_empty = (sp_reg == '0);
        status.rep_end     = (i_reg >= NODE_LIM);
        status.rep_cut     = (i_reg < NODE_LIM) && cut_reg[i_idx];
        status.out_busy    = out_valid_reg;
        status.no_cuts     = (cut_total_reg == '0);
    end

    // Memories: no reset, guarded by the valid, visited and cut vectors.
    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_EDGE: begin
                if (edge_ok) begin
                    if (fwd_valid_reg[a_idx]) begin
                        fwd_mem[a_idx][b_idx] <= 1'b1;
                    end else begin
                        fwd_mem[a_idx] <= NODES'(1) << b_idx;
                    end
                    if (rev_valid_reg[b_idx]) begin
                        rev_mem[b_idx][a_idx] <= 1'b1;
                    end else begin
                        rev_mem[b_idx] <= NODES'(1) << a_idx;
                    end
                end
            end
            OP_ROOT_START: begin
                vis_mem[i_idx] <= vcnt_reg + 1'b1;
            end
            OP_FETCH: begin
                fwd_rd_reg  <= fwd_mem[u_idx];
                rev_rd_reg  <= rev_mem[u_idx];
                fwd_rdv_reg <= fwd_valid_reg[u_idx];
                rev_rdv_reg <= rev_valid_reg[u_idx];
            end
            OP_SCAN: begin
                vis_rd_reg <= vis_mem[w_node[IDX_W-1:0]];
            end
            OP_PUSH: begin
                stack_mem[sp_reg] <= push_frame;
                vis_mem[w_idx]    <= vcnt_reg + 1'b1;
            end
            OP_POP: begin
                if (cut_now) begin
                    sub_mem[u_idx] <= fin_count[CNT_W-1:0];
                end
                if (sp_reg != '0) begin
                    stack_rd_reg <= stack_mem[sp_reg - 1'b1];
                end
            end
            OP_REP_SCAN: begin
                sub_rd_reg <= sub_mem[i_idx];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_valid_reg <= '0;
            rev_valid_reg <= '0;
            visited_reg   <= '0;
            cut_reg       <= '0;
            sp_reg        <= '0;
            i_reg         <= '0;
            vcnt_reg      <= '0;
            net_reg       <= '0;
            cut_total_reg <= '0;
            rep_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (out_valid_reg && m_tready) begin
                out_valid_reg <= 1'b0;
            end
            case (cmd.op)
                OP_EDGE: begin
                    if (edge_ok) begin
                        fwd_valid_reg[a_idx] <= 1'b1;
                        rev_valid_reg[b_idx] <= 1'b1;
                    end
                end
                OP_RSCAN_INIT: begin
                    i_reg <= PTR_W'(1);
                end
                OP_RSCAN: begin
                    if (!status.root_hit && !status.rscan_end) begin
                        i_reg <= i_reg + 1'b1;
                    end
                end
                OP_ROOT_START: begin
                    frame_reg.u     <= i_reg[NODE_W-1:0];
                    frame_reg.par   <= '0;
                    frame_reg.nxt   <= '0;
                    frame_reg.child <= '0;
                    frame_reg.vis   <= vcnt_reg + 1'b1;
                    frame_reg.low   <= vcnt_reg + 1'b1;
                    frame_reg.split <= '0;
                    vcnt_reg           <= vcnt_reg + 1'b1;
                    visited_reg[i_idx] <= 1'b1;
                    sp_reg             <= '0;
                end
                OP_SCAN: begin
                    if (found) begin
                        frame_reg.nxt <= w_ptr + 1'b1;
                        w_reg         <= w_node;
                    end else if (!scan_done) begin
                        frame_reg.nxt <= next_base;
                    end
                end
                OP_VCMP: begin
                    if (vis_rd_reg < frame_reg.low) begin
                        frame_reg.low <= vis_rd_reg;
                    end
                end
                OP_PUSH: begin
                    frame_reg          <= new_frame;
                    sp_reg             <= sp_reg + 1'b1;
                    vcnt_reg           <= vcnt_reg + 1'b1;
                    visited_reg[w_idx] <= 1'b1;
                end
                OP_POP: begin
                    if (cut_now) begin
                        cut_reg[u_idx] <= 1'b1;
                        cut_total_reg  <= cut_total_reg + 1'b1;
                    end
                end
                OP_UNWIND: begin
                    frame_reg <= up_frame;
                    sp_reg    <= sp_reg - 1'b1;
                end
                OP_REP_START: begin
                    net_reg <= net_reg + 1'b1;
                    i_reg   <= PTR_W'(1);
                end
                OP_REP_SCAN: begin
                    if (!status.rep_cut && !status.rep_end) begin
                        i_reg <= i_reg + 1'b1;
                    end
                end
                OP_EMIT: begin
                    out_data_reg  <= {PAD_W'(0), sub_rd_reg, i_reg[NODE_W-1:0], net_reg};
                    out_last_reg  <= ((rep_cnt_reg + 1'b1) == cut_total_reg);
                    out_none_reg  <= 1'b0;
                    out_valid_reg <= 1'b1;
                    rep_cnt_reg   <= rep_cnt_reg + 1'b1;
                    i_reg         <= i_reg + 1'b1;
                end
                OP_EMIT_NONE: begin
                    out_data_reg  <= {PAD_W'(0), CNT_W'(0), NODE_W'(0), net_reg};
                    out_last_reg  <= 1'b1;
                    out_none_reg  <= 1'b1;
                    out_valid_reg <= 1'b1;
                end
                OP_CLEAR: begin
                    fwd_valid_reg <= '0;
                    rev_valid_reg <= '0;
                    visited_reg   <= '0;
                    cut_reg       <= '0;
                    vcnt_reg      <= '0;
                    cut_total_reg <= '0;
                    rep_cnt_reg   <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_none   = out_none_reg;

    a_load_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_EMIT || cmd.op == OP_EMIT_NONE) |-> !out_valid_reg)
        else $error("result loaded over an untaken beat");

    a_clear_cuts: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_CLEAR) |=> (cut_reg == '0 && visited_reg == '0))
        else $error("walk state survived the clear");

    a_vcnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        vcnt_reg <= VIS_W'(NODES))
        else $error("visit counter beyond node count");

    a_rep_count: assert property (@(posedge aclk) disable iff (!aresetn)
        rep_cnt_reg <= cut_total_reg)
        else $error("more cut results reported than found");

endmodule

// ===== design/articulation_point_finder.sv =====
// Edge beats stream at one per cycle while s_tready is high; it drops while a walk runs.
// An end beat runs the walk: a root search over the nodes; per tree node a push, row fetch,
// pop, unwind and parent row fetch; a scan step per 8-bit row chunk passed, per neighbor
// found and per row end, and a compare step per back edge; then a report pass over the
// nodes that emits each cut vertex and waits out any output stall, and a clear step.
// Reset (aresetn low, synchronous) clears all valid bits and counters; no clearing pass.
// ----------------------------------------------------------------------------
// articulation_point_finder: cut vertex search over a streamed graph
// Loads undirected edges into an adjacency matrix, then on an end beat
// runs a depth-first low-link walk and streams out the cut vertices.
// ----------------------------------------------------------------------------
module articulation_point_finder #(
    parameter int MAX_NODES = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [apf_pkg::S_DATA_W-1:0]  s_tdata,   // node_a [5:0], node_b [11:6], zero
    input  logic [0:0]                    s_tuser,   // kind [0]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [apf_pkg::M_DATA_W-1:0]  m_tdata,   // network_number [15:0],
                                                     // cut_node [21:16],
                                                     // subnet_count [27:22], zero
    output logic                          m_tlast,   // last
    output logic [0:0]                    m_tuser    // none_found [0]
);
    import apf_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;
    logic       none_bit;

    apf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_kind   (s_tuser[0]),
        .status   (status),
        .cmd      (cmd)
    );

    apf_datapath #(
        .MAX_NODES (MAX_NODES)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .edge_a   (s_tdata[NODE_W-1:0]),
        .edge_b   (s_tdata[2*NODE_W-1:NODE_W]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_none   (none_bit)
    );

    assign m_tuser[0] = none_bit;

endmodule
